>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the tokenizer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("tokenizer assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("tokenizer assertion failed");

`endif

>>> hw/rtl/tllt_pkg.sv
// ----------------------------------------------------------------------------
// Type list line tokenizer package
// Character codes, parser states, mark codes and the context structs.
// ----------------------------------------------------------------------------
`default_nettype none

package tllt_pkg;

	localparam int unsigned LEN_W = 12;

	// Reset value of the token length limit: line buffer of 4096 less one.
	localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(4096 - 1);

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	localparam logic [1:0] CLS_NONE  = 2'd0;
	localparam logic [1:0] CLS_NAME  = 2'd1;
	localparam logic [1:0] CLS_VALUE = 2'd2;

	localparam logic [1:0] TEND_NONE  = 2'd0;
	localparam logic [1:0] TEND_NAME  = 2'd1;
	localparam logic [1:0] TEND_VALUE = 2'd2;

	typedef enum logic [2:0] {
		ST_LINE    = 3'd0,
		ST_NAME    = 3'd1,
		ST_GAP     = 3'd2,
		ST_VALUE   = 3'd3,
		ST_VGAP    = 3'd4,
		ST_COMMENT = 3'd5
	} parse_state_t;

	// Parser context carried from one byte to the next.
	typedef struct packed {
		parse_state_t     state;
		logic [LEN_W-1:0] len;
		logic             err;
	} ctx_t;

	// Marks produced for one byte.
	typedef struct packed {
		logic [1:0] cls;
		logic       start;
		logic [1:0] tend;
		logic       rend;
		logic       err;
	} marks_t;

endpackage

`default_nettype wire

>>> hw/rtl/type_list_line_tokenizer.sv
// ----------------------------------------------------------------------------
// Type list line tokenizer
// Streams a type list text one byte per beat and marks names and values.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   in        sink       in_valid / in_stall   in_byte
//   out       source     out_valid / out_stall out_byte, char_class,
//                                              token_start, token_end,
//                                              record_end, parse_error
//   cfg       sink       cfg_wr_en             cfg_wr_data (token limit)
//
// One byte is taken every cycle while the output side keeps up; each input
// beat gives exactly one output beat, after it has passed through the
// input register and then the result register; the parser context is
// updated as a byte moves from one to the other.
// Reset clears the valid flags, the parser context and restores the limit.
// An output stall holds the result register; a byte may still be taken into
// the input register while the result waits, so in_stall rises only when
// both registers are full and the output is stalled.
//
// ----------------------------------------------------------------------------
`default_nettype none

module type_list_line_tokenizer
	import tllt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,

	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       in_byte,

	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       out_byte,
	output logic [1:0]       char_class,
	output logic             token_start,
	output logic [1:0]       token_end,
	output logic             record_end,
	output logic             parse_error,

	input  logic             cfg_wr_en,
	input  logic [LEN_W-1:0] cfg_wr_data
);

	// Pipeline control.
	logic             valid_s1;
	logic             valid_s2;
	logic             s2_free;
	logic             s1_ready;
	logic             s1_fire;

	// Payload registers.
	logic [7:0]       byte_s1;
	logic [7:0]       byte_s2;
	marks_t           marks_s2;

	// Parser context and the token limit.
	ctx_t             ctx_q;
	ctx_t             ctx_nxt;
	marks_t           marks;
	logic [LEN_W-1:0] max_len_q;

	// The result register can load when it is empty or is being emptied.
	assign s2_free  = !valid_s2 || !out_stall;
	assign s1_fire  = valid_s1 && s2_free;
	assign s1_ready = !valid_s1 || s2_free;
	assign in_stall = !s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	// The user must write the limit only while nothing is in flight; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	tllt_step u_step (
		.ctx     (ctx_q),
		.ch      (byte_s1),
		.max_len (max_len_q),
		.ctx_nxt (ctx_nxt),
		.marks   (marks)
	);

	// The context advances exactly once per byte, as it enters the result
	// register, so the next byte in the input register sees it at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q <= '{state: ST_LINE, len: '0, err: 1'b0};
		end else if (s1_fire) begin
			ctx_q <= ctx_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			byte_s2  <= byte_s1;
			marks_s2 <= marks;
		end
	end

	assign out_valid   = valid_s2;
	assign out_byte    = byte_s2;
	assign char_class  = marks_s2.cls;
	assign token_start = marks_s2.start;
	assign token_end   = marks_s2.tend;
	assign record_end  = marks_s2.rend;
	assign parse_error = marks_s2.err;

endmodule

`default_nettype wire

>>> hw/rtl/tllt_step.sv
// ----------------------------------------------------------------------------
// Tokenizer step
// Next context and output marks for one text byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tllt_step
	import tllt_pkg::*;
(
	input  ctx_t             ctx,
	input  logic [7:0]       ch,
	input  logic [LEN_W-1:0] max_len,
	output ctx_t             ctx_nxt,
	output marks_t           marks
);

	logic   eol;
	logic   len_hit;
	logic   fail;
	ctx_t   nxt;
	marks_t mk;

	assign eol     = (ch == CH_CR) || (ch == CH_LF);
	assign len_hit = ctx.len >= max_len;

	always_comb begin
		nxt  = ctx;
		mk   = '0;
		fail = 1'b0;
		case (ctx.state)
			ST_LINE: begin
				if (ch == CH_HASH) begin
					nxt.state = ST_COMMENT;
				end else if (!eol) begin
					mk.cls    = CLS_NAME;
					mk.start  = 1'b1;
					nxt.len   = LEN_W'(1);
					nxt.state = ST_NAME;
				end
			end
			ST_NAME: begin
				if (ch == CH_SPACE) begin
					mk.tend   = TEND_NAME;
					nxt.state = ST_GAP;
				end else if (eol || len_hit) begin
					fail = 1'b1;
				end else begin
					mk.cls  = CLS_NAME;
					nxt.len = ctx.len + LEN_W'(1);
				end
			end
			ST_GAP: begin
				if (eol) begin
					fail = 1'b1;
				end else if (ch != CH_SPACE) begin
					mk.cls    = CLS_VALUE;
					mk.start  = 1'b1;
					nxt.len   = LEN_W'(1);
					nxt.state = ST_VALUE;
				end
			end
			ST_VALUE: begin
				if ((ch == CH_SPACE) || (ch == CH_COMMA)) begin
					mk.tend   = TEND_VALUE;
					nxt.state = ST_VGAP;
				end else if (eol) begin
					mk.tend   = TEND_VALUE;
					mk.rend   = 1'b1;
					nxt.state = ST_LINE;
				end else if (len_hit) begin
					fail = 1'b1;
				end else begin
					mk.cls  = CLS_VALUE;
					nxt.len = ctx.len + LEN_W'(1);
				end
			end
			ST_VGAP: begin
				if (eol) begin
					mk.rend   = 1'b1;
					nxt.state = ST_LINE;
				end else if ((ch != CH_SPACE) && (ch != CH_COMMA)) begin
					mk.cls    = CLS_VALUE;
					mk.start  = 1'b1;
					nxt.len   = LEN_W'(1);
					nxt.state = ST_VALUE;
				end
			end
			ST_COMMENT: begin
				if (eol) begin
					nxt.state = ST_LINE;
				end
			end
			default: begin
				fail = 1'b1;
			end
		endcase

		// A failing byte carries no token marks and only sets the error flag.
		if (fail) begin
			nxt     = ctx;
			nxt.err = 1'b1;
			mk      = '0;
		end

		// Once in error the parser is frozen.
		if (ctx.err) begin
			nxt = ctx;
			mk  = '0;
		end

		mk.err = nxt.err;
	end

	assign ctx_nxt = nxt;
	assign marks   = mk;

endmodule

`default_nettype wire

>>> hw/rtl/tllt_checker.sv
// ----------------------------------------------------------------------------
// Tokenizer checker
// Port-level assertions on the output marks, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tllt_checker
	import tllt_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       out_valid,
	input  wire logic       out_stall,
	input  wire logic [7:0] out_byte,
	input  wire logic [1:0] char_class,
	input  wire logic       token_start,
	input  wire logic [1:0] token_end,
	input  wire logic       record_end,
	input  wire logic       parse_error
);

	logic out_fire;
	logic seen_err_q;

	assign out_fire = out_valid && !out_stall;

	// Remembers that an error beat has left the block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_err_q <= 1'b0;
		end else if (out_fire && parse_error) begin
			seen_err_q <= 1'b1;
		end
	end

	// The error flag never drops once it has been shown.
	`ASSERT_IMPLY(a_err_sticky, clk, arst_n, out_valid && seen_err_q, parse_error)

	// Beats with the error set carry no token marks.
	`ASSERT_IMPLY(a_err_no_marks, clk, arst_n, out_valid && parse_error,
		(char_class == CLS_NONE) && !token_start && (token_end == TEND_NONE) && !record_end)

	// A token start is always a token byte, and an ending byte never is.
	`ASSERT_IMPLY(a_start_is_text, clk, arst_n, out_valid && (token_start || (token_end != TEND_NONE)),
		(token_start != (token_end != TEND_NONE)) && ((char_class == CLS_NONE) == (token_end != TEND_NONE)))

	// A stalled result beat stays put.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(out_byte) && $stable(char_class) && $stable(parse_error))

endmodule

bind type_list_line_tokenizer tllt_checker u_tllt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.out_byte    (out_byte),
	.char_class  (char_class),
	.token_start (token_start),
	.token_end   (token_end),
	.record_end  (record_end),
	.parse_error (parse_error)
);

`default_nettype wire

>>> tb/sv/type_list_line_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// Type list line tokenizer testbench
// Streams type list text through the tokenizer under random valid and stall
// gaps, and checks every output beat against a cycle-free copy of the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module type_list_line_tokenizer_tb;
	import tllt_pkg::*;

	// Cycles with no beat on either channel before the run is abandoned.
	// The longest honest quiet spell is the output hold-off.
	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam int unsigned PRINT_CAP   = 40;

	// Ways of breaking the stream in the final phase. The error is sticky
	// until reset, and reset is applied once, so only one is used per run.
	typedef enum int {
		BRK_EOL_NAME,
		BRK_EOL_GAP,
		BRK_LONG_NAME,
		BRK_LONG_VALUE
	} break_kind_t;

	// One output beat: the echoed byte and its marks.
	typedef struct packed {
		logic [7:0] b;
		logic [1:0] cls;
		logic       start;
		logic [1:0] tend;
		logic       rend;
		logic       err;
	} tok_beat_t;

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             in_valid    = 1'b0;
	logic [7:0]       in_byte     = 8'h00;
	logic             out_stall   = 1'b0;
	logic             cfg_wr_en   = 1'b0;
	logic [LEN_W-1:0] cfg_wr_data = '0;

	logic             in_stall;
	logic             out_valid;
	logic [7:0]       out_byte;
	logic [1:0]       char_class;
	logic             token_start;
	logic [1:0]       token_end;
	logic             record_end;
	logic             parse_error;

	// Text waiting to be sent, and the beats the parser copy says must come.
	logic [7:0] byte_q [$];
	tok_beat_t  tok_q [$];

	// Parser copy: its own context and its own view of the token limit.
	parse_state_t     tk_state = ST_LINE;
	logic [LEN_W-1:0] tk_len   = '0;
	logic             tk_err   = 1'b0;
	logic [LEN_W-1:0] tk_limit = MAX_LEN_RESET;

	// Limit that the text generator respects so that tokens stay legal.
	int unsigned gen_limit = MAX_LEN_RESET;

	int unsigned n_in      = 0;
	int unsigned n_out     = 0;
	int unsigned n_err     = 0;
	int unsigned n_names   = 0;
	int unsigned n_values  = 0;
	int unsigned n_records = 0;
	int unsigned n_cfg     = 0;
	int unsigned quiet     = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;
	break_kind_t brk_kind;
	tok_beat_t   want_in;
	tok_beat_t   want_out;

	// A short opening text: comment, bare LF, CR LF pair at line start, a
	// name that is a comma, a record ended by CR with the LF left over as an
	// empty line, a name that is a single space, a zero byte as a value, a
	// 0xFF value ended by LF, and a record whose last gap holds a comma.
	logic [7:0] directed_bytes [24] = '{
		CH_HASH, 8'h63, CH_LF,
		CH_LF,
		CH_CR, CH_LF,
		CH_COMMA, CH_SPACE, 8'h78, CH_CR, CH_LF,
		CH_SPACE, CH_SPACE, 8'h00, CH_COMMA, 8'hFF, CH_LF,
		8'h6E, CH_SPACE, CH_SPACE, 8'h61, CH_SPACE, CH_COMMA, CH_LF
	};

	wire in_fire  = in_valid && !in_stall;
	wire out_fire = out_valid && !out_stall;

	// No idling on either side during this stretch, so that the block also
	// sees long back-to-back runs of beats.
	wire calm = (n_in >= 500) && (n_in < 650);

	type_list_line_tokenizer i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.char_class  (char_class),
		.token_start (token_start),
		.token_end   (token_end),
		.record_end  (record_end),
		.parse_error (parse_error),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Advances the parser copy by one byte and returns the beat it implies.
	// Once the error flag is set the context is frozen and every byte comes
	// back with no marks and the flag raised.
	function automatic tok_beat_t tokenize_byte(input logic [7:0] c);
		tok_beat_t r;
		logic      fail;
		logic      eol;
		r    = '0;
		r.b  = c;
		fail = 1'b0;
		eol  = (c == CH_CR) || (c == CH_LF);
		if (!tk_err) begin
			case (tk_state)
				ST_LINE: begin
					// Anything but a hash or a line end opens a name, even a
					// space or a comma.
					if (c == CH_HASH) begin
						tk_state = ST_COMMENT;
					end else if (!eol) begin
						r.cls    = CLS_NAME;
						r.start  = 1'b1;
						tk_len   = LEN_W'(1);
						tk_state = ST_NAME;
					end
				end
				ST_NAME: begin
					if (c == CH_SPACE) begin
						r.tend   = TEND_NAME;
						tk_state = ST_GAP;
					end else if (eol || tk_len >= tk_limit) begin
						fail = 1'b1;
					end else begin
						r.cls  = CLS_NAME;
						tk_len = tk_len + LEN_W'(1);
					end
				end
				ST_GAP: begin
					// A comma here is not a separator but the first value byte.
					if (eol) begin
						fail = 1'b1;
					end else if (c != CH_SPACE) begin
						r.cls    = CLS_VALUE;
						r.start  = 1'b1;
						tk_len   = LEN_W'(1);
						tk_state = ST_VALUE;
					end
				end
				ST_VALUE: begin
					if (c == CH_SPACE || c == CH_COMMA) begin
						r.tend   = TEND_VALUE;
						tk_state = ST_VGAP;
					end else if (eol) begin
						r.tend   = TEND_VALUE;
						r.rend   = 1'b1;
						tk_state = ST_LINE;
					end else if (tk_len >= tk_limit) begin
						fail = 1'b1;
					end else begin
						r.cls  = CLS_VALUE;
						tk_len = tk_len + LEN_W'(1);
					end
				end
				ST_VGAP: begin
					if (eol) begin
						r.rend   = 1'b1;
						tk_state = ST_LINE;
					end else if (c != CH_SPACE && c != CH_COMMA) begin
						r.cls    = CLS_VALUE;
						r.start  = 1'b1;
						tk_len   = LEN_W'(1);
						tk_state = ST_VALUE;
					end
				end
				ST_COMMENT: begin
					if (eol) begin
						tk_state = ST_LINE;
					end
				end
				default: begin
					fail = 1'b1;
				end
			endcase
			if (fail) begin
				tk_err = 1'b1;
				r      = '0;
				r.b    = c;
			end
		end
		r.err = tk_err;
		return r;
	endfunction

	// Random byte that is never a line end, with further exclusions on request.
	function automatic logic [7:0] pick_byte(input bit no_space, input bit no_comma,
			input bit no_hash);
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(0, 255));
		end while (c == CH_CR || c == CH_LF || (no_space && c == CH_SPACE) ||
				(no_comma && c == CH_COMMA) || (no_hash && c == CH_HASH));
		return c;
	endfunction

	// Token length within the limit: mostly short, sometimes at the limit or
	// at 40 if less. A limit of zero still lets a one-byte token through.
	function automatic int unsigned pick_len();
		int unsigned top;
		int unsigned cap;
		int unsigned r;
		top = (gen_limit == 0) ? 1 : gen_limit;
		cap = (top < 40) ? top : 40;
		r   = $urandom_range(0, 9);
		if (r == 0) begin
			return cap;
		end else if (r < 3) begin
			return $urandom_range(1, cap);
		end
		return $urandom_range(1, (cap < 6) ? cap : 6);
	endfunction

	task automatic push_run(input int unsigned n, input bit is_name, input bit after_gap);
		int unsigned k;
		for (k = 0; k < n; k++) begin
			if (is_name) begin
				byte_q.push_back((k == 0) ? pick_byte(1'b0, 1'b0, 1'b1)
						: pick_byte(1'b1, 1'b0, 1'b0));
			end else begin
				byte_q.push_back((k == 0) ? pick_byte(1'b1, !after_gap, 1'b0)
						: pick_byte(1'b1, 1'b1, 1'b0));
			end
		end
	endtask

	task automatic push_eol();
		case ($urandom_range(0, 2))
			0: begin
				byte_q.push_back(CH_LF);
			end
			1: begin
				byte_q.push_back(CH_CR);
			end
			default: begin
				byte_q.push_back(CH_CR);
				byte_q.push_back(CH_LF);
			end
		endcase
	endtask

	task automatic push_separators();
		repeat ($urandom_range(1, 3)) begin
			byte_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_COMMA);
		end
	endtask

	// A well-formed record: name, gap, one to four values, line end, with
	// a trailing separator run before the line end now and then.
	task automatic push_record();
		int unsigned nv;
		int unsigned k;
		push_run(pick_len(), 1'b1, 1'b0);
		byte_q.push_back(CH_SPACE);
		repeat ($urandom_range(0, 2)) byte_q.push_back(CH_SPACE);
		nv = $urandom_range(1, 4);
		for (k = 0; k < nv; k++) begin
			push_run(pick_len(), 1'b0, k == 0);
			if (k + 1 < nv || $urandom_range(0, 2) == 0) begin
				push_separators();
			end
		end
		push_eol();
	endtask

	task automatic fill_phase(input int unsigned target);
		int unsigned r;
		while (byte_q.size() < target) begin
			r = $urandom_range(0, 19);
			if (r < 14) begin
				push_record();
			end else if (r < 17) begin
				byte_q.push_back(CH_HASH);
				repeat ($urandom_range(0, 10)) byte_q.push_back(pick_byte(1'b0, 1'b0, 1'b0));
				push_eol();
			end else begin
				push_eol();
			end
		end
	endtask

	// Breaks the stream in one of the ways the parser must flag.
	task automatic push_broken(input break_kind_t kind);
		int unsigned top;
		top = (gen_limit == 0) ? 1 : gen_limit;
		case (kind)
			BRK_EOL_NAME: begin
				push_run($urandom_range(1, top), 1'b1, 1'b0);
				push_eol();
			end
			BRK_EOL_GAP: begin
				push_run(pick_len(), 1'b1, 1'b0);
				byte_q.push_back(CH_SPACE);
				push_eol();
			end
			BRK_LONG_NAME: begin
				push_run(top + 1, 1'b1, 1'b0);
			end
			default: begin
				push_run(pick_len(), 1'b1, 1'b0);
				byte_q.push_back(CH_SPACE);
				push_run(top + 1, 1'b0, 1'b1);
			end
		endcase
	endtask

	// The sender stops until every expected beat has been seen; checked on
	// the falling edge, when nothing is in motion.
	task automatic wait_drained();
		@(negedge clk);
		while (byte_q.size() != 0 || in_valid || tok_q.size() != 0) @(negedge clk);
	endtask

	// Only ever called with the block drained, so no byte is in flight.
	task automatic write_limit(input int unsigned v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= LEN_W'(v);
		tk_limit    = LEN_W'(v);
		gen_limit   = v;
		n_cfg++;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		if (n_err < PRINT_CAP) begin
			$display("MISMATCH at output beat %0d: %s got %0h, expected %0h",
					n_out, what, got, exp_val);
		end
		n_err++;
	endtask

	task automatic check_field(input string what, input int got, input int exp_val);
		if (got != exp_val) begin
			report_mismatch(what, got, exp_val);
		end
	endtask

	// Driver. A beat that is accepted at this edge is run through the parser
	// copy at once; the next beat is offered at random, but in the calm stretch
	// and the output hold-off it is offered every cycle that the slot is free.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte  <= 8'h00;
		end else begin
			if (in_fire) begin
				want_in = tokenize_byte(in_byte);
				tok_q.push_back(want_in);
				n_in <= n_in + 1;
				if (want_in.tend == TEND_NAME) n_names++;
				if (want_in.tend == TEND_VALUE) n_values++;
				if (want_in.rend) n_records++;
			end
			// A stalled beat is held as it is; otherwise the slot is free.
			if (!in_valid || !in_stall) begin
				if (byte_q.size() != 0 &&
						(calm || hold_left != 0 || $urandom_range(0, 99) >= 34)) begin
					in_valid <= 1'b1;
					in_byte  <= byte_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor. Each accepted output beat is checked field by field against
	// the oldest prediction. The stall is random outside the calm stretch, apart
	// from one long hold-off while plenty of text is still queued, so that the
	// input register and the result register both fill and in_stall must rise.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_fire) begin
				n_out <= n_out + 1;
				if (tok_q.size() == 0) begin
					report_mismatch("beat with nothing pending, out_byte", out_byte, 0);
				end else begin
					want_out = tok_q.pop_front();
					check_field("out_byte", out_byte, want_out.b);
					check_field("char_class", char_class, want_out.cls);
					check_field("token_start", token_start, want_out.start);
					check_field("token_end", token_end, want_out.tend);
					check_field("record_end", record_end, want_out.rend);
					check_field("parse_error", parse_error, want_out.err);
				end
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (!hold_done && byte_q.size() > 100) begin
				out_stall <= 1'b1;
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(0, 99) < 34);
			end
		end
	end

	// Watchdog: a run with no beat on either side for too long has hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_fire || out_fire) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	// Stimulus sequence. Each phase after the opening text starts from a
	// drained block, sets a new token limit and queues its text. Errors are
	// kept to the last phase because the flag can only be cleared by a reset.
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Opening text at the reset limit.
		@(negedge clk);
		foreach (directed_bytes[k]) byte_q.push_back(directed_bytes[k]);

		// The first long phase is where the output hold-off lands.
		wait_drained();
		write_limit(MAX_LEN_RESET);
		fill_phase(300);

		// Extremes of the limit, then a spread of small and large values.
		wait_drained();
		write_limit(1);
		fill_phase(80);
		wait_drained();
		write_limit(0);
		fill_phase(80);
		repeat (3) begin
			wait_drained();
			write_limit($urandom_range(2, 12));
			fill_phase(90);
		end
		repeat (2) begin
			wait_drained();
			write_limit($urandom_range(13, 4094));
			fill_phase(90);
		end
		wait_drained();
		write_limit(MAX_LEN_RESET);
		fill_phase(80);

		// Final phase: a few good lines at a small limit, one broken line,
		// then raw noise that must all come back frozen with the flag set.
		wait_drained();
		write_limit($urandom_range(0, 5));
		fill_phase(20);
		brk_kind = break_kind_t'($urandom_range(0, 3));
		push_broken(brk_kind);
		repeat (40) byte_q.push_back(8'($urandom_range(0, 255)));

		wait_drained();
		// Allow a margin for a stray beat.
		repeat (10) @(posedge clk);
		if (tok_q.size() != 0) begin
			report_mismatch("beats never delivered, count", 0, tok_q.size());
		end

		$display("Run covered %0d bytes in, %0d beats out, %0d limit writes.",
				n_in, n_out, n_cfg);
		$display("Saw %0d names, %0d values, %0d records; stream broken by %s.",
				n_names, n_values, n_records, brk_kind.name());
		if (n_err == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
+incdir+hw/rtl
hw/rtl/tllt_pkg.sv
hw/rtl/tllt_step.sv
hw/rtl/type_list_line_tokenizer.sv
hw/rtl/tllt_checker.sv
tb/sv/type_list_line_tokenizer_tb.sv
